[src/dpy_pkg.sv]
// shared types, constants and functions for the direction to pitch/yaw block
`default_nettype none
package dpy_pkg;

	localparam int COORD_WIDTH   = 24;
	localparam int CORDIC_STAGES = 24;
	localparam int PRESCALE      = 58 - COORD_WIDTH;
	localparam int VEC_W         = 64;
	localparam int ANG_W         = 44;
	localparam int ANG_FRAC      = 32;
	localparam int OUT_W         = 17;

	localparam logic [31:0] INV_GAIN = 32'h9B74EDA8;
	localparam logic signed [ANG_W-1:0] DEG180 = ANG_W'(64'd180 << ANG_FRAC);
	localparam logic signed [ANG_W-1:0] DEG360 = ANG_W'(64'd360 << ANG_FRAC);
	localparam logic [19:0] DEG360_Q8 = 20'd92160;
	localparam logic [OUT_W-1:0] PITCH_UP   = OUT_W'(270 * 256);
	localparam logic [OUT_W-1:0] PITCH_DOWN = OUT_W'(90 * 256);

	typedef logic signed [VEC_W-1:0] vec_t;
	typedef logic signed [ANG_W-1:0] ang_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] src_x;
		logic signed [COORD_WIDTH-1:0] src_y;
		logic signed [COORD_WIDTH-1:0] src_z;
		logic signed [COORD_WIDTH-1:0] dst_x;
		logic signed [COORD_WIDTH-1:0] dst_y;
		logic signed [COORD_WIDTH-1:0] dst_z;
	} in_t;

	typedef struct packed {
		logic [OUT_W-1:0] pitch_angle;
		logic [OUT_W-1:0] yaw_angle;
	} out_t;

	// data that rides alongside a cordic pass
	typedef struct packed {
		vec_t ny;       // -dz, prescaled
		ang_t zy;       // yaw accumulator once pass one is done
		logic flat;     // dx and dy both zero
		logic dz_pos;
	} side_t;

	typedef struct packed {
		vec_t  x;
		vec_t  y;
		ang_t  z;
		side_t side;
	} job_t;

	function automatic ang_t atan_lut(input int i);
		logic signed [63:0] v;
		case (i)
			0: v = 64'sd193273528320;  1: v = 64'sd114096026022;
			2: v = 64'sd60285206653;   3: v = 64'sd30601712202;
			4: v = 64'sd15360239180;   5: v = 64'sd7687607525;
			6: v = 64'sd3844741810;    7: v = 64'sd1922488225;
			8: v = 64'sd961258780;     9: v = 64'sd480631223;
			10: v = 64'sd240315841;    11: v = 64'sd120157949;
			12: v = 64'sd60078978;     13: v = 64'sd30039490;
			14: v = 64'sd15019745;     15: v = 64'sd7509872;
			16: v = 64'sd3754936;      17: v = 64'sd1877468;
			18: v = 64'sd938734;       19: v = 64'sd469367;
			20: v = 64'sd234684;       21: v = 64'sd117342;
			22: v = 64'sd58671;        23: v = 64'sd29335;
			24: v = 64'sd14668;        25: v = 64'sd7334;
			26: v = 64'sd3667;         27: v = 64'sd1833;
			28: v = 64'sd917;          29: v = 64'sd458;
			30: v = 64'sd229;          31: v = 64'sd115;
			default: v = 64'sd0;
		endcase
		return v[ANG_W-1:0];
	endfunction

	// wrap into [0,360), round half up to 8 fraction bits
	function automatic logic [OUT_W-1:0] to_q8(input ang_t z);
		ang_t zz;
		ang_t rnd;
		logic [19:0] q;
		zz = (z < 0) ? z + DEG360 : z;
		if (zz < 0) zz = '0;
		rnd = zz + ANG_W'(64'd1 << (ANG_FRAC - 9));
		q = rnd[ANG_FRAC-8+19:ANG_FRAC-8];
		if (q >= DEG360_Q8) q = q - DEG360_Q8;
		return q[OUT_W-1:0];
	endfunction

endpackage
`default_nettype wire

[src/dpy_front.sv]
// front end: forms the direction, classifies it and prescales it for cordic
`default_nettype none
module dpy_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire dpy_pkg::in_t in_beat,
	output logic              job_valid,
	input  wire logic         job_full,
	output dpy_pkg::job_t     job
);
	import dpy_pkg::*;

	logic signed [COORD_WIDTH:0] dx, dy, dz;
	vec_t sx, sy, sz;
	job_t job_d;
	job_t job_s1;
	logic valid_s1;

	always_comb begin
		dx = {in_beat.dst_x[COORD_WIDTH-1], in_beat.dst_x} - {in_beat.src_x[COORD_WIDTH-1], in_beat.src_x};
		dy = {in_beat.dst_y[COORD_WIDTH-1], in_beat.dst_y} - {in_beat.src_y[COORD_WIDTH-1], in_beat.src_y};
		dz = {in_beat.dst_z[COORD_WIDTH-1], in_beat.dst_z} - {in_beat.src_z[COORD_WIDTH-1], in_beat.src_z};
		sx = VEC_W'(dx) <<< PRESCALE;
		sy = VEC_W'(dy) <<< PRESCALE;
		sz = VEC_W'(dz) <<< PRESCALE;
		job_d.side.ny     = -sz;
		job_d.side.zy     = '0;
		job_d.side.flat   = (dx == '0) && (dy == '0);
		job_d.side.dz_pos = (dz > 0);
		// left half plane: flip the vector and start from 180
		if (dx < 0) begin
			job_d.x = -sx;
			job_d.y = -sy;
			job_d.z = DEG180;
		end else begin
			job_d.x = sx;
			job_d.y = sy;
			job_d.z = '0;
		end
	end

	assign in_stall  = valid_s1 && job_full;
	assign job_valid = valid_s1;
	assign job       = job_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			job_s1 <= job_d;
		end
	end

endmodule
`default_nettype wire

[src/dpy_queue.sv]
// two-entry queue between the front end and the cordic back end
`default_nettype none
module dpy_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire dpy_pkg::job_t push_job,
	output logic               full,
	input  wire logic          pop,
	output logic               empty,
	output dpy_pkg::job_t      pop_job
);
	import dpy_pkg::*;

	job_t mem_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;
	logic do_push, do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_job = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (do_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_job;
		end
	end

endmodule
`default_nettype wire

[src/dpy_cordic.sv]
// pipelined vectoring cordic, one stage per register
`default_nettype none
module dpy_cordic (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire dpy_pkg::job_t in_job,
	output logic               out_valid,
	output dpy_pkg::job_t      out_job
);
	import dpy_pkg::*;

	job_t job_s [CORDIC_STAGES+1];
	logic valid_s [CORDIC_STAGES+1];

	assign job_s[0]   = in_job;
	assign valid_s[0] = in_valid;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		job_t nxt;
		always_comb begin
			nxt = job_s[i];
			if (job_s[i].y >= 0) begin
				nxt.x = job_s[i].x + (job_s[i].y >>> i);
				nxt.y = job_s[i].y - (job_s[i].x >>> i);
				nxt.z = job_s[i].z + atan_lut(i);
			end else begin
				nxt.x = job_s[i].x - (job_s[i].y >>> i);
				nxt.y = job_s[i].y + (job_s[i].x >>> i);
				nxt.z = job_s[i].z - atan_lut(i);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i+1] <= 1'b0;
			end else if (en) begin
				valid_s[i+1] <= valid_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				job_s[i+1] <= nxt;
			end
		end
	end

	assign out_valid = valid_s[CORDIC_STAGES];
	assign out_job   = job_s[CORDIC_STAGES];

endmodule
`default_nettype wire

[src/dpy_back.sv]
// back end: yaw pass, gain correction, pitch pass and output rounding
`default_nettype none
module dpy_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          job_empty,
	input  wire dpy_pkg::job_t job,
	output logic               job_pop,
	output logic               out_valid,
	input  wire logic          out_stall,
	output dpy_pkg::out_t      out_beat
);
	import dpy_pkg::*;

	logic adv;
	logic p1_valid, p2_valid;
	job_t p1_job, p2_job;
	logic g1_valid_s1, g2_valid_s2;
	logic [31:0] lo_s1;
	logic [30:0] hi_s1;
	side_t side_d;
	side_t side_s1;
	vec_t rc_s2;
	side_t side_s2;
	job_t p2_in;
	logic out_valid_q;
	out_t out_q;
	vec_t ru;

	assign adv     = !out_valid_q || !out_stall;
	assign job_pop = adv && !job_empty;

	dpy_cordic u_yaw (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (job_pop),
		.in_job    (job),
		.out_valid (p1_valid),
		.out_job   (p1_job)
	);

	assign ru = (p1_job.x > 0) ? p1_job.x : '0;

	always_comb begin
		side_d    = p1_job.side;
		side_d.zy = p1_job.z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g1_valid_s1 <= 1'b0;
			g2_valid_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			g1_valid_s1 <= p1_valid;
			g2_valid_s2 <= g1_valid_s1;
			out_valid_q <= p2_valid;
		end
	end

	// magnitude times 1/K, split into a 32-bit low half and a 31-bit high half
	always_ff @(posedge clk) begin
		if (adv) begin
			lo_s1   <= ru[31:0];
			hi_s1   <= ru[62:32];
			side_s1 <= side_d;
			rc_s2   <= VEC_W'(64'(hi_s1) * 64'(INV_GAIN))
				+ VEC_W'((64'(lo_s1) * 64'(INV_GAIN)) >> 32);
			side_s2 <= side_s1;
		end
	end

	always_comb begin
		p2_in.x    = rc_s2;
		p2_in.y    = side_s2.ny;
		p2_in.z    = '0;
		p2_in.side = side_s2;
	end

	dpy_cordic u_pitch (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (g2_valid_s2),
		.in_job    (p2_in),
		.out_valid (p2_valid),
		.out_job   (p2_job)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			if (p2_job.side.flat) begin
				out_q.pitch_angle <= p2_job.side.dz_pos ? PITCH_UP : PITCH_DOWN;
				out_q.yaw_angle   <= '0;
			end else begin
				out_q.pitch_angle <= to_q8(p2_job.z);
				out_q.yaw_angle   <= to_q8(p2_job.side.zy);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_beat  = out_q;

endmodule
`default_nettype wire

[src/direction_to_pitch_yaw.sv]
// top level: direction between two points to pitch and yaw angles
// usage:
//  in channel: in_valid/in_stall with in_beat holding source and destination
//  points, signed q15.8; a beat moves when in_valid is high and in_stall low
//  out channel: out_valid/out_stall with out_beat holding pitch_angle and
//  yaw_angle in degrees, unsigned q9.8, range 0 to just under 360
//  throughput: one beat per clock while the output is not stalled
//  path from input beat to output beat: front register, queue, yaw cordic,
//  two gain-multiply stages, pitch cordic, output register; the two unrolled
//  cordic pipelines make up most of it
//  when the receiver stalls, the back pipeline holds; the two-entry queue and
//  the front register keep taking beats until full, then in_stall rises
//  reset clears all valid flags; no beat is in flight after reset
`default_nettype none
module direction_to_pitch_yaw (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire dpy_pkg::in_t in_beat,
	output logic              out_valid,
	input  wire logic         out_stall,
	output dpy_pkg::out_t     out_beat
);
	import dpy_pkg::*;

	logic f_valid, q_full, q_empty, q_pop;
	job_t f_job, q_job;

	dpy_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_beat   (in_beat),
		.job_valid (f_valid),
		.job_full  (q_full),
		.job       (f_job)
	);

	dpy_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (f_valid),
		.push_job (f_job),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.pop_job  (q_job)
	);

	dpy_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_empty (q_empty),
		.job       (q_job),
		.job_pop   (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_beat  (out_beat)
	);

endmodule
`default_nettype wire

[dv/testbench.sv]
// testbench for direction_to_pitch_yaw: directed and random point pairs against a cordic predictor
`timescale 1ns / 100ps
`default_nettype none
module testbench;
	import dpy_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int LATENCY = 2 * CORDIC_STAGES + 5;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_t in_beat;
	logic out_valid;
	logic out_stall;
	out_t out_beat;

	out_t angle_q[$];
	int fail_count;
	int send_idle_pct;
	int stall_pct;
	int quiet_cycles;

	direction_to_pitch_yaw uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_beat(in_beat),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_beat(out_beat)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic longint shift_floor(longint v, int s);
		return v >>> s;
	endfunction

	// vectoring pass: drives y toward zero, accumulates angle, returns x
	function automatic longint rotate_to_axis(longint x, longint y, ref longint acc);
		longint xs;
		longint ys;
		longint tbl[32];
		tbl = '{64'sd193273528320, 64'sd114096026022, 64'sd60285206653, 64'sd30601712202,
			64'sd15360239180, 64'sd7687607525, 64'sd3844741810, 64'sd1922488225,
			64'sd961258780, 64'sd480631223, 64'sd240315841, 64'sd120157949,
			64'sd60078978, 64'sd30039490, 64'sd15019745, 64'sd7509872,
			64'sd3754936, 64'sd1877468, 64'sd938734, 64'sd469367,
			64'sd234684, 64'sd117342, 64'sd58671, 64'sd29335,
			64'sd14668, 64'sd7334, 64'sd3667, 64'sd1833,
			64'sd917, 64'sd458, 64'sd229, 64'sd115};
		for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
			xs = shift_floor(x, i);
			ys = shift_floor(y, i);
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				acc = acc + tbl[i];
			end else begin
				x = x - ys;
				y = y + xs;
				acc = acc - tbl[i];
			end
		end
		return x;
	endfunction

	function automatic logic [OUT_W-1:0] degrees_q8(longint z);
		longint q;
		if (z < 0) z = z + (longint'(360) <<< ANG_FRAC);
		if (z < 0) z = 0;
		q = longint'((longint'(z) + (longint'(1) <<< (ANG_FRAC - 9))) >>> (ANG_FRAC - 8));
		while (q >= 92160) q = q - 92160;
		return q[OUT_W-1:0];
	endfunction

	function automatic out_t predict_angles(in_t b);
		out_t r;
		longint dx, dy, dz, x, y, yaw_acc, pitch_acc, mag;
		logic [63:0] mu, mc;
		dx = longint'(b.dst_x) - longint'(b.src_x);
		dy = longint'(b.dst_y) - longint'(b.src_y);
		dz = longint'(b.dst_z) - longint'(b.src_z);
		yaw_acc = 0;
		pitch_acc = 0;
		if (dx == 0 && dy == 0) begin
			r.pitch_angle = (dz > 0) ? PITCH_UP : PITCH_DOWN;
			r.yaw_angle = '0;
			return r;
		end
		x = dx <<< PRESCALE;
		y = dy <<< PRESCALE;
		if (dx < 0) begin
			x = -x;
			y = -y;
			yaw_acc = longint'(180) <<< ANG_FRAC;
		end
		mag = rotate_to_axis(x, y, yaw_acc);
		mu = (mag > 0) ? 64'(mag) : 64'd0;
		mc = (mu >> 32) * 64'(INV_GAIN) + (((mu & 64'hFFFFFFFF) * 64'(INV_GAIN)) >> 32);
		void'(rotate_to_axis(longint'(mc), -(dz <<< PRESCALE), pitch_acc));
		r.pitch_angle = degrees_q8(pitch_acc);
		r.yaw_angle = degrees_q8(yaw_acc);
		return r;
	endfunction

	task automatic send_points(in_t b);
		while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_beat <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		angle_q.push_back(predict_angles(b));
		@(negedge clk);
	endtask

	function automatic logic [23:0] rand_coord();
		case ($urandom_range(5, 0))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return 24'($urandom_range(16, 0)) - 24'd8;
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic in_t rand_points();
		in_t b;
		b = {rand_coord(), rand_coord(), rand_coord(),
			rand_coord(), rand_coord(), rand_coord()};
		// often make the horizontal part vanish or share a coordinate
		case ($urandom_range(9, 0))
			0: begin
				b.dst_x = b.src_x;
				b.dst_y = b.src_y;
			end
			1: b.dst_x = b.src_x;
			2: b.dst_y = b.src_y;
			3: b.dst_z = b.src_z;
			default: ;
		endcase
		return b;
	endfunction

	// receiver side: stall and check
	always @(negedge clk) begin
		out_stall <= (stall_pct > 0) && ($urandom_range(99, 0) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (angle_q.size() == 0) begin
				$error("result beat with none expected");
				fail_count++;
			end else begin
				if (out_beat.pitch_angle !== angle_q[0].pitch_angle) begin
					$error("pitch_angle expected %0d actual %0d",
						angle_q[0].pitch_angle, out_beat.pitch_angle);
					fail_count++;
				end
				if (out_beat.yaw_angle !== angle_q[0].yaw_angle) begin
					$error("yaw_angle expected %0d actual %0d",
						angle_q[0].yaw_angle, out_beat.yaw_angle);
					fail_count++;
				end
				void'(angle_q.pop_front());
			end
		end
	end

	// watchdog over cycles where no beat moves
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic test_special_cases();
		in_t b;
		b = '0;
		send_points(b);
		b.dst_z = 24'sd5;
		send_points(b);
		b.dst_z = -24'sd5;
		send_points(b);
		b = '0;
		b.dst_x = -24'sd100;
		send_points(b);
		b.dst_y = 24'sd0;
		b.dst_x = 24'sd100;
		send_points(b);
		b = '0;
		b.dst_y = -24'sd1;
		send_points(b);
		b.dst_y = 24'sd1;
		send_points(b);
		b = '0;
		b.dst_x = -24'sd1;
		b.dst_y = -24'sd1;
		send_points(b);
		b.dst_x = -24'sd1;
		b.dst_y = 24'sd1;
		send_points(b);
	endtask

	task automatic test_extremes();
		in_t b;
		b = {24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF};
		send_points(b);
		b = {24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000};
		send_points(b);
		b = {24'h7FFFFF, 24'h800000, 24'h000000, 24'h800000, 24'h7FFFFF, 24'hFFFFFF};
		send_points(b);
		b = {24'h000000, 24'h000000, 24'h7FFFFF, 24'h000001, 24'h000000, 24'h800000};
		send_points(b);
		b = {24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h000000};
		send_points(b);
		b = {24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA};
		send_points(b);
	endtask

	task automatic test_random(int count, int idle, int stall);
		send_idle_pct = idle;
		stall_pct = stall;
		repeat (count) send_points(rand_points());
	endtask

	initial begin
		fail_count = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_beat = '0;
		out_stall = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_special_cases();
		test_extremes();
		test_random(500, 0, 0);
		test_random(480, 69, 0);
		test_random(480, 0, 69);
		test_random(480, 6, 6);
		// last beat has moved, drop valid
		in_valid <= 1'b0;
		while (angle_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
`default_nettype wire
